// ----- rtl/tss_pkg.sv -----
// Package for the three-sum search: sequencer states.
package tss_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_SWAP,
    ST_SRCH_INIT,
    ST_RD_I,
    ST_RD_LO,
    ST_RD_HI,
    ST_SUM,
    ST_CMP,
    ST_OUT
  } state_t;
endpackage

// ----- rtl/three_sum_triplet_search.sv -----
// Three-sum search: load a set, sort it in place, run the two-pointer scan.
// Values load one per cycle while in_ready is high. On the item marked
// last_value the block drops in_ready, sorts the stored n values with an
// odd-even transposition sort through one memory (n passes of about n/2
// neighbour pairs; each pair is read, compared and, when it swaps, written
// back in two writes), then runs the two-pointer scan: read element i, then
// for each pointer move read lo and hi, sum and compare, for up to about
// n*n/2 moves. The single result is held in the output register until taken;
// loading of the next set resumes once it is accepted.
module three_sum_triplet_search #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_last_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_target_sum
);
  import tss_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMENTS);

  logic signed [31:0] mem [MAX_ELEMENTS];
  logic signed [31:0] rdata_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pass_r, pass_nxt;   // sort pass count
  logic [CW-1:0] j_r, j_nxt;         // sort pair index / search i
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [31:0] a_r, a_nxt;    // first read / element i
  logic signed [33:0] acc_r, acc_nxt;
  logic sw_r, sw_nxt;                // swap write phase
  logic signed [31:0] tgt_r, tgt_nxt;
  logic found_r, found_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] wdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign out_found = found_r;
  assign tgt_nxt   = cfg_valid ? cfg_target_sum : tgt_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_value) begin
          state_nxt = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        if (pass_r >= cnt_r || cnt_r < CW'(2)) begin
          state_nxt = ST_SRCH_INIT;
        end else if (j_r + CW'(1) >= cnt_r) begin
          state_nxt = ST_SORT_RD;
        end else if (!sw_r) begin
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP:  state_nxt = ST_SORT_SWAP;
      ST_SORT_SWAP: state_nxt = ST_SORT_RD;
      ST_SRCH_INIT: state_nxt = (cnt_r < CW'(3)) ? ST_OUT : ST_RD_I;
      ST_RD_I: begin
        if (j_r + CW'(2) >= cnt_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD_LO;
        end
      end
      ST_RD_LO: state_nxt = ST_RD_HI;
      ST_RD_HI: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (acc_r == 34'(tgt_r)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD_LO;
          if (acc_r < 34'(tgt_r)) begin
            if (lo_r + CW'(1) >= hi_r) state_nxt = ST_RD_I;
          end else begin
            if (lo_r + CW'(1) >= hi_r) state_nxt = ST_RD_I;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    j_nxt     = j_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    a_nxt     = a_r;
    acc_nxt   = acc_r;
    sw_nxt    = sw_r;
    found_nxt = found_r;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wdata     = in_value;
    raddr     = j_r[AW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < MAXC) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_last_value) begin
            pass_nxt = '0;
            j_nxt    = '0;
            sw_nxt   = 1'b0;
          end
        end
      end
      ST_SORT_RD: begin
        // read element j; j+1 read next cycle
        raddr = j_r[AW-1:0];
        if (pass_r >= cnt_r || cnt_r < CW'(2)) begin
          j_nxt = '0;
        end else if (j_r + CW'(1) >= cnt_r) begin
          pass_nxt = pass_r + CW'(1);
          j_nxt    = {{(CW-1){1'b0}}, ~pass_r[0]};
        end
      end
      ST_SORT_CMP: begin
        raddr = AW'(j_r + CW'(1));
        a_nxt = rdata_r;
      end
      ST_SORT_SWAP: begin
        if (a_r > rdata_r) begin
          // write back the smaller one now, the larger via sw cycle below
          we    = 1'b1;
          waddr = j_r[AW-1:0];
          wdata = rdata_r;
          acc_nxt = 34'(a_r);
          sw_nxt  = 1'b1;
        end else begin
          j_nxt = j_r + CW'(2);
        end
      end
      ST_SRCH_INIT: begin
        j_nxt     = '0;
        found_nxt = 1'b0;
      end
      ST_RD_I: begin
        raddr  = j_r[AW-1:0];
        lo_nxt = j_r + CW'(1);
        hi_nxt = cnt_r - CW'(1);
      end
      ST_RD_LO: begin
        raddr = lo_r[AW-1:0];
        if (state_r == ST_RD_LO && lo_r == j_r + CW'(1) && hi_r == cnt_r - CW'(1)) begin
          a_nxt = rdata_r;
        end
      end
      ST_RD_HI: begin
        raddr   = hi_r[AW-1:0];
        acc_nxt = 34'(a_r) + 34'(rdata_r);
      end
      ST_SUM: begin
        acc_nxt = acc_r + 34'(rdata_r);
      end
      ST_CMP: begin
        if (acc_r == 34'(tgt_r)) begin
          found_nxt = 1'b1;
        end else begin
          if (acc_r < 34'(tgt_r)) lo_nxt = lo_r + CW'(1);
          else hi_nxt = hi_r - CW'(1);
          if (lo_r + CW'(1) >= hi_r) j_nxt = j_r + CW'(1);
        end
      end
      ST_OUT: begin
        if (out_ready) cnt_nxt = '0;
      end
      default: ;
    endcase
    // second write of a swap: larger value into j+1
    if (sw_r) begin
      we     = 1'b1;
      waddr  = AW'(j_r + CW'(1));
      wdata  = acc_r[31:0];
      sw_nxt = 1'b0;
      j_nxt  = j_r + CW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      sw_r    <= 1'b0;
      tgt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sw_r    <= sw_nxt;
      tgt_r   <= tgt_nxt;
      found_r <= found_nxt;
    end
    pass_r <= pass_nxt;
    j_r    <= j_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXC)
    else $error("element count beyond store depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result dropped before taken");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
      state_r != ST_LOAD |-> !in_ready)
    else $error("ready while searching");
endmodule
